// ===== src/ppds_pkg.sv =====
// Package for the pairwise point distance statistics block.
// Holds request/response payload types and the controller state type.
`timescale 1ns / 1ps
package ppds_pkg;
   localparam int CoordW = 24;
   localparam int DistW  = 25;
   localparam int PairW  = 11;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic [DistW-1:0] mean_distance;
      logic [DistW-1:0] peak_distance;
      logic [PairW-1:0] pair_count;
      logic             no_pairs;
      logic             overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_PAIRS, ST_DRAIN, ST_DIV, ST_OUT
   } state_type;
endpackage

// ===== src/pairwise_point_distance_stats.sv =====
// Top level of the pairwise point distance statistics block.
// Uses ppds_pkg, ppds_ram (point store) and ppds_cell (square root chain).
`timescale 1ns / 1ps
// Usage:
//  Requests on req_* carry one 3D point each; a point with last set closes
//  the set. Points load at one per cycle while requests are taken. A last
//  point starts the compute phase: for each pair (i, j), i < j, one read of
//  the store per cycle feeds a squared distance stage and then a chain of 26
//  root cells, one bit per cell, so pairs flow at one per cycle, except for
//  the read that fetches point i at the start of each row. The pair walk is
//  followed by a drain of the chain and a bit serial divide that forms the
//  mean; a set of under two points goes straight to the result.
//  Sustained throughput is set by the single store read port.
//  No requests are taken during compute. While a result waits in the rsp_*
//  register the next set may load, but its last point is held off until
//  that result has been taken. Points beyond MAX_POINTS are dropped and
//  flagged. A stalled response holds its payload. Reset empties the store
//  count and clears the flags; store contents stay undefined until written.
module pairwise_point_distance_stats import ppds_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS+1);
   localparam int SW  = 52;
   localparam int NC  = 26;
   localparam int PCW = 2*CW;            // pair count width
   localparam int SUW = DistW + PCW;     // distance sum width
   localparam int RW  = 3*CoordW;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic          drop_ff;
   logic [AW-1:0] i_ff, j_ff;
   logic          rd_vld_ff;
   logic [CoordW-1:0] ix_ff, iy_ff, iz_ff;
   logic          load_i_ff;
   logic [RW-1:0] rd_data;
   logic [AW-1:0] rd_addr;
   logic [SW-1:0] sq_ff;
   logic          sq_vld_ff;
   logic [SUW-1:0] sum_ff;
   logic [DistW-1:0] max_ff;
   logic [PCW-1:0] pairs_ff;
   logic [SUW-1:0] quo_ff, rem_ff;
   logic [$clog2(SUW+1)-1:0] dcnt_ff;
   rsp_type rsp_ff;
   logic    rsp_vld_ff;
   logic    accept, wr_en, pair_issue, last_pair;

   assign accept = req_valid && !req_stall;
   assign wr_en  = accept && (count_ff < CW'(MAX_POINTS));

   ppds_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data({req_data.x, req_data.y, req_data.z}),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // pair walk: fetch point i once, then j = i+1 .. count-1
   logic in_pairs;
   assign in_pairs   = (state_ff == ST_PAIRS);
   assign rd_addr    = load_i_ff ? i_ff : j_ff;
   assign pair_issue = in_pairs && !load_i_ff;
   assign last_pair  = pair_issue && (CW'(j_ff) == count_ff - CW'(1))
                       && (CW'(i_ff) == count_ff - CW'(2));

   logic rd_is_i_ff;
   always_ff @(posedge clock) begin
      rd_is_i_ff <= in_pairs && load_i_ff;
      if (reset) rd_vld_ff <= 1'b0;
      else       rd_vld_ff <= pair_issue;
      if (rd_is_i_ff) {ix_ff, iy_ff, iz_ff} <= rd_data;
      if (state_ff != ST_PAIRS) begin
         i_ff <= '0; j_ff <= AW'(1); load_i_ff <= 1'b1;
      end else if (load_i_ff) begin
         load_i_ff <= 1'b0;
      end else if (CW'(j_ff) == count_ff - CW'(1)) begin
         i_ff <= i_ff + 1'b1; j_ff <= i_ff + AW'(2); load_i_ff <= 1'b1;
      end else begin
         j_ff <= j_ff + 1'b1;
      end
   end

   // squared distance stage
   logic signed [CoordW:0] dx, dy, dz;
   logic [CoordW-1:0] ax, ay, az;
   logic [2*CoordW-1:0] px, py, pz;
   assign dx = {ix_ff[CoordW-1], ix_ff} - {rd_data[RW-1], rd_data[RW-1 -: CoordW]};
   assign dy = {iy_ff[CoordW-1], iy_ff}
             - {rd_data[2*CoordW-1], rd_data[2*CoordW-1 -: CoordW]};
   assign dz = {iz_ff[CoordW-1], iz_ff} - {rd_data[CoordW-1], rd_data[CoordW-1:0]};
   assign ax = dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
   assign ay = dy[CoordW] ? CoordW'(-dy) : CoordW'(dy);
   assign az = dz[CoordW] ? CoordW'(-dz) : CoordW'(dz);
   assign px = ax * ax;
   assign py = ay * ay;
   assign pz = az * az;

   always_ff @(posedge clock) begin
      sq_ff <= SW'(px) + SW'(py) + SW'(pz);
      if (reset) sq_vld_ff <= 1'b0;
      else       sq_vld_ff <= rd_vld_ff;
   end

   // root chain, one cell per result bit
   logic [SW-1:0] rem_c [NC+1];
   logic [SW-1:0] root_c [NC+1];
   logic          vld_c [NC+1];
   assign rem_c[0]  = sq_ff;
   assign root_c[0] = '0;
   assign vld_c[0]  = sq_vld_ff;
   for (genvar k = 0; k < NC; k++) begin : g_cell
      ppds_cell #(.W(SW), .K(NC-1-k)) u_cell (
         .clock(clock), .reset(reset), .vld_i(vld_c[k]), .rem_i(rem_c[k]),
         .root_i(root_c[k]), .vld_o(vld_c[k+1]), .rem_o(rem_c[k+1]),
         .root_o(root_c[k+1]));
   end
   logic [DistW-1:0] pair_dist;
   assign pair_dist = root_c[NC][DistW-1:0];

   // drain counter: wait for the chain to empty
   logic [4:0] drain_ff;
   logic pipe_busy;
   assign pipe_busy = rd_vld_ff || sq_vld_ff;

   // controller next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:  if (accept && req_data.last)
                      state_in = (count_ff + CW'(wr_en) >= CW'(2)) ? ST_PAIRS : ST_OUT;
         ST_PAIRS: if (last_pair) state_in = ST_DRAIN;
         ST_DRAIN: if (drain_ff == 5'(NC+3)) state_in = ST_DIV;
         ST_DIV:   if (dcnt_ff == '0) state_in = ST_OUT;
         ST_OUT:   state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // controller outputs: a last point waits for the result register to free
   always_comb begin
      req_stall = (state_ff != ST_LOAD) || (rsp_vld_ff && req_data.last);
   end

   logic [SUW:0] trial;
   assign trial = {rem_ff, quo_ff[SUW-1]} - {1'b0, SUW'(pairs_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= '0; drop_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_vld_ff && !rsp_stall) rsp_vld_ff <= 1'b0;
         if (accept) begin
            if (wr_en) count_ff <= count_ff + 1'b1;
            else       drop_ff  <= 1'b1;
         end
         if (state_ff != ST_OUT && state_in == ST_OUT) begin
            rsp_vld_ff <= 1'b1; count_ff <= '0; drop_ff <= 1'b0;
         end
      end
      // statistics accumulation
      if (state_ff == ST_LOAD) begin
         sum_ff <= '0; max_ff <= '0; pairs_ff <= '0; drain_ff <= '0;
      end else if (vld_c[NC]) begin
         sum_ff   <= sum_ff + SUW'(pair_dist);
         pairs_ff <= pairs_ff + 1'b1;
         if (pair_dist > max_ff) max_ff <= pair_dist;
      end
      if (state_ff == ST_DRAIN) drain_ff <= pipe_busy ? 5'd0 : drain_ff + 1'b1;
      // bit serial restoring divide
      if (state_ff == ST_DRAIN) begin
         quo_ff <= sum_ff; rem_ff <= '0; dcnt_ff <= ($bits(dcnt_ff))'(SUW);
      end else if (state_ff == ST_DIV && dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (!trial[SUW]) begin
            rem_ff <= trial[SUW-1:0]; quo_ff <= {quo_ff[SUW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[SUW-2:0], quo_ff[SUW-1]}; quo_ff <= {quo_ff[SUW-2:0], 1'b0};
         end
      end
      if (state_ff != ST_OUT && state_in == ST_OUT) begin
         rsp_ff.overflowed <= drop_ff || (accept && !wr_en);
         if (state_ff == ST_LOAD) begin
            rsp_ff.mean_distance <= '0; rsp_ff.peak_distance <= '0;
            rsp_ff.pair_count <= '0; rsp_ff.no_pairs <= 1'b1;
         end else begin
            rsp_ff.mean_distance <= quo_ff[DistW-1:0];
            rsp_ff.peak_distance <= max_ff;
            rsp_ff.pair_count    <= PairW'(pairs_ff);
            rsp_ff.no_pairs      <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // no last point taken while a result is pending
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && req_data.last |-> !accept)
      else $error("last point accepted while result pending");
   // store count never exceeds capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS)) else $error("point count beyond capacity");
   // result payload holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_stall |=> $stable(rsp_ff)) else $error("result changed under stall");
endmodule

// ===== src/ppds_cell.sv =====
// One cell of the root chain: a single bit step of the integer square root.
// Depends on ppds_pkg only through the house import.
`timescale 1ns / 1ps
module ppds_cell import ppds_pkg::*; #(
   parameter int W = 52,
   parameter int K = 0
) (
   input  logic         clock,
   input  logic         vld_i,
   input  logic [W-1:0] rem_i,
   input  logic [W-1:0] root_i,
   output logic         vld_o,
   output logic [W-1:0] rem_o,
   output logic [W-1:0] root_o,
   input  logic         reset
);
   localparam logic [W-1:0] Bit = W'(1) << (2*K);
   logic [W-1:0] rem_ff, root_ff, trial;
   logic         vld_ff;

   assign trial = root_i + Bit;

   // one restoring step, registered toward the next cell
   always_ff @(posedge clock) begin
      if (rem_i >= trial) begin
         rem_ff  <= rem_i - trial;
         root_ff <= (root_i >> 1) + Bit;
      end else begin
         rem_ff  <= rem_i;
         root_ff <= root_i >> 1;
      end
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_i;
   end

   assign vld_o  = vld_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
endmodule

// ===== src/ppds_ram.sv =====
// Generic single write, single read RAM with registered read.
// No dependencies beyond the package import.
`timescale 1ns / 1ps
module ppds_ram import ppds_pkg::*; #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule
